// ===== design/i2p_pkg.sv =====
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, constants and character helpers for the infix-to-postfix block
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_POW   = 8'h5e;
  localparam logic [7:0] CH_MUL   = 8'h2a;
  localparam logic [7:0] CH_DIV   = 8'h2f;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_ADD   = 8'h2b;
  localparam logic [7:0] CH_SUB   = 8'h2d;

  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_POW  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MOD  = 3'd4,
    OP_ADD  = 3'd5,
    OP_SUB  = 3'd6,
    OP_NONE = 3'd7
  } op_code_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_UNB = 2'd2
  } status_t;

  typedef struct packed {
    logic     push;
    logic     pop;
    op_code_t code;
  } stk_cmd_t;

  function automatic op_code_t char_to_code(input logic [7:0] ch);
    op_code_t c;
    unique case (ch)
      CH_OPEN: c = OP_OPEN;
      CH_POW:  c = OP_POW;
      CH_MUL:  c = OP_MUL;
      CH_DIV:  c = OP_DIV;
      CH_MOD:  c = OP_MOD;
      CH_ADD:  c = OP_ADD;
      CH_SUB:  c = OP_SUB;
      default: c = OP_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] code_to_char(input op_code_t c);
    logic [7:0] ch;
    unique case (c)
      OP_OPEN: ch = CH_OPEN;
      OP_POW:  ch = CH_POW;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      OP_MOD:  ch = CH_MOD;
      OP_ADD:  ch = CH_ADD;
      OP_SUB:  ch = CH_SUB;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prio(input op_code_t c);
    logic [1:0] p;
    unique case (c)
      OP_POW:                 p = 2'd3;
      OP_MUL, OP_DIV, OP_MOD: p = 2'd2;
      OP_ADD, OP_SUB:         p = 2'd1;
      default:                p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== design/i2p_cell.sv =====
// ----------------------------------------------------------------------------
// i2p_cell
// One stack entry; loads from the entry above on push, from below on pop
// ----------------------------------------------------------------------------
module i2p_cell (
  input  logic              clk,
  input  logic              push,
  input  logic              pop,
  input  i2p_pkg::op_code_t from_above,
  input  i2p_pkg::op_code_t from_below,
  output i2p_pkg::op_code_t entry
);
  import i2p_pkg::*;

  op_code_t entry_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r <= from_above;
    end else if (pop) begin
      entry_r <= from_below;
    end
  end

  assign entry = entry_r;

endmodule

// ===== design/i2p_stack.sv =====
// ----------------------------------------------------------------------------
// i2p_stack
// Operator stack built as a row of shifting cells, top in cell zero
// ----------------------------------------------------------------------------
module i2p_stack (
  input  logic                    clk,
  input  logic                    rst_n,
  input  i2p_pkg::stk_cmd_t       cmd,
  output i2p_pkg::op_code_t       top,
  output logic [i2p_pkg::CNT_W-1:0] count,
  output logic                    full
);
  import i2p_pkg::*;

  op_code_t             ent [STACK_DEPTH];
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;

  genvar i;
  generate
    for (i = 0; i < STACK_DEPTH; i++) begin : g_cell
      op_code_t above;
      op_code_t below;
      if (i == 0) begin : g_top
        assign above = cmd.code;
      end else begin : g_mid
        assign above = ent[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_end
        assign below = OP_OPEN;
      end else begin : g_nend
        assign below = ent[i+1];
      end
      i2p_cell u_cell (
        .clk        (clk),
        .push       (cmd.push),
        .pop        (cmd.pop),
        .from_above (above),
        .from_below (below),
        .entry      (ent[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign top   = ent[0];
  assign count = count_r;
  assign full  = (count_r == CNT_W'(STACK_DEPTH));

endmodule

// ===== design/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream to postfix order
// ----------------------------------------------------------------------------
//   channel   dir   tdata                        tuser      tlast
//   in_       in    [7:0] in_char                -          is_last
//   out_      out   [7:0] out_char, [9:8] status has_char   end_of_expr
//
// an operator or ')' pops the operators that it releases one at a time, since
// the operator stack shifts one entry per cycle while no pop is held back;
// the last character then flushes every remaining entry and closes out
// an emitting pop or a new input character waits while the held result and the output register are full and stalled
// synchronous active-low reset empties the stack and clears the error flags
// the newest result of a character is held back, so the end mark is exact
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_char
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_char, [9:8] status, [15:10] zero
  output logic [0:0]  out_tuser,  // [0] has_char
  output logic        out_tlast
);
  import i2p_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_CLOSE,
    S_PUSH,
    S_OPER,
    S_FLUSH,
    S_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       ch_r;
  logic             last_r;
  op_code_t         code_r;
  logic [1:0]       flags_r;
  logic             hold_v_r;
  logic [7:0]       hold_char_r;
  logic             out_valid_r;
  logic [7:0]       out_char_r;
  logic             out_has_r;
  logic             out_end_r;
  status_t          out_status_r;

  stk_cmd_t         cmd;
  op_code_t         top;
  logic [CNT_W-1:0] count;
  logic             full;

  logic             emit_ok, can_hold, gen_v, fin, set_ovf, set_unb, drain;
  logic [7:0]       gen_char;
  op_code_t         in_code;
  state_t           after;
  logic [1:0]       flags_fin;

  i2p_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .top   (top),
    .count (count),
    .full  (full)
  );

  assign emit_ok   = !out_valid_r || out_tready;
  assign can_hold  = !hold_v_r || emit_ok;
  assign drain     = (state_r == S_IDLE) && hold_v_r && emit_ok;
  assign in_code   = char_to_code(in_tdata);
  assign after     = last_r ? S_FLUSH : S_IDLE;
  assign flags_fin = flags_r;

  always_comb begin
    cmd       = '{push: 1'b0, pop: 1'b0, code: code_r};
    gen_v     = 1'b0;
    gen_char  = code_to_char(top);
    fin       = 1'b0;
    set_ovf   = 1'b0;
    set_unb   = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tdata == CH_CLOSE) begin
            state_nxt = S_CLOSE;
          end else if (in_code == OP_OPEN) begin
            state_nxt = S_PUSH;
          end else if (in_code != OP_NONE) begin
            state_nxt = S_OPER;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (can_hold) begin
          gen_v     = 1'b1;
          gen_char  = ch_r;
          state_nxt = after;
        end
      end
      S_CLOSE: begin
        if (count == '0) begin
          set_unb   = 1'b1;
          state_nxt = after;
        end else if (top == OP_OPEN) begin
          cmd.pop   = 1'b1;
          state_nxt = after;
        end else if (can_hold) begin
          gen_v   = 1'b1;
          cmd.pop = 1'b1;
        end
      end
      S_PUSH: begin
        if (full) begin
          set_ovf = 1'b1;
        end else begin
          cmd.push = 1'b1;
        end
        state_nxt = after;
      end
      S_OPER: begin
        if (count != '0 && code_prio(top) >= code_prio(code_r)) begin
          if (can_hold) begin
            gen_v   = 1'b1;
            cmd.pop = 1'b1;
          end
        end else begin
          if (full) begin
            set_ovf = 1'b1;
          end else begin
            cmd.push = 1'b1;
          end
          state_nxt = after;
        end
      end
      S_FLUSH: begin
        if (count == '0) begin
          state_nxt = S_FIN;
        end else if (top == OP_OPEN) begin
          cmd.pop = 1'b1;
          set_unb = 1'b1;
        end else if (can_hold) begin
          gen_v   = 1'b1;
          cmd.pop = 1'b1;
        end
      end
      S_FIN: begin
        if (emit_ok) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_tvalid && in_tready) begin
        ch_r   <= in_tdata;
        last_r <= in_tlast;
        code_r <= in_code;
      end
      if (fin) begin
        out_valid_r  <= 1'b1;
        out_char_r   <= hold_v_r ? hold_char_r : 8'h00;
        out_has_r    <= hold_v_r;
        out_end_r    <= 1'b1;
        out_status_r <= flags_fin[1] ? ST_UNB : (flags_fin[0] ? ST_OVF : ST_OK);
        hold_v_r     <= 1'b0;
        flags_r      <= '0;
      end else begin
        flags_r <= flags_r | {set_unb, set_ovf};
        if (gen_v) begin
          hold_v_r    <= 1'b1;
          hold_char_r <= gen_char;
          if (hold_v_r) begin
            out_valid_r  <= 1'b1;
            out_char_r   <= hold_char_r;
            out_has_r    <= 1'b1;
            out_end_r    <= 1'b0;
            out_status_r <= ST_OK;
          end else if (out_tready) begin
            out_valid_r <= 1'b0;
          end
        end else if (drain) begin
          hold_v_r     <= 1'b0;
          out_valid_r  <= 1'b1;
          out_char_r   <= hold_char_r;
          out_has_r    <= 1'b1;
          out_end_r    <= 1'b0;
          out_status_r <= ST_OK;
        end else if (out_tready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE) && (!hold_v_r || emit_ok);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_char_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_end_r;

`ifndef SYNTHESIS
  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[9:8] == ST_OK)
    else $error("status set on a transaction before the end");

  a_bare_marker_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata[7:0] == 8'h00)
    else $error("bare marker away from the end");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_empty_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |-> count == '0)
    else $error("stack not empty at end of expression");
`endif

endmodule

// ===== dv/infix_to_postfix_converter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_test
// Self-checking bench: streams infix characters into the converter, predicts
// the postfix output with a shunting-yard predictor of its own, and checks
// every output transaction in order. A directed table covers the corner cases
// and is followed by random well-formed, deeply nested and noise expressions.
// Traffic runs under several idle/stall mixes plus one long output hold-off.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_test;
  import i2p_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_CHARS  = 85;
  localparam int PRESS_CHARS  = 40;
  localparam int N_DIR        = 23;

  typedef struct packed {
    logic [7:0] ch;
    logic       has;
    logic       eoe;
    logic [1:0] st;
  } postfix_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    postfix_t   res;
  } dir_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  infix_to_postfix_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  logic [7:0]  op_sym  [8] = '{CH_OPEN, CH_POW, CH_MUL, CH_DIV, CH_MOD, CH_ADD, CH_SUB,
                               8'h00};
  int unsigned op_rank [8] = '{0, 3, 2, 2, 2, 1, 1, 0};

  dir_row_t dir_tbl [N_DIR] = '{
    '{"a",      1'b1, 1'b1, '{"a",    1'b1, 1'b1, ST_OK}},
    '{8'h00,    1'b1, 1'b1, '{8'h00,  1'b1, 1'b1, ST_OK}},
    '{8'hff,    1'b1, 1'b1, '{8'hff,  1'b1, 1'b1, ST_OK}},
    '{CH_CLOSE, 1'b1, 1'b1, '{8'h00,  1'b0, 1'b1, ST_UNB}},
    '{CH_OPEN,  1'b1, 1'b1, '{8'h00,  1'b0, 1'b1, ST_UNB}},
    '{CH_ADD,   1'b1, 1'b1, '{CH_ADD, 1'b1, 1'b1, ST_OK}},
    '{"a",      1'b0, 1'b0, '0},
    '{CH_POW,   1'b0, 1'b0, '0},
    '{"b",      1'b0, 1'b0, '0},
    '{CH_MUL,   1'b0, 1'b0, '0},
    '{"c",      1'b0, 1'b0, '0},
    '{CH_MOD,   1'b0, 1'b0, '0},
    '{"d",      1'b0, 1'b0, '0},
    '{CH_DIV,   1'b0, 1'b0, '0},
    '{"e",      1'b0, 1'b0, '0},
    '{CH_SUB,   1'b0, 1'b0, '0},
    '{"f",      1'b0, 1'b0, '0},
    '{CH_ADD,   1'b0, 1'b0, '0},
    '{CH_OPEN,  1'b0, 1'b0, '0},
    '{"g",      1'b0, 1'b0, '0},
    '{CH_POW,   1'b0, 1'b0, '0},
    '{"h",      1'b0, 1'b0, '0},
    '{CH_CLOSE, 1'b1, 1'b0, '0}
  };

  int unsigned src_pct  [4] = '{0, 71, 0, 9};
  int unsigned sink_pct [4] = '{0, 0, 71, 9};

  // predictor state
  op_code_t    op_stk [STACK_DEPTH];
  int unsigned op_depth = 0;
  logic        ovf_seen = 1'b0;
  logic        unb_seen = 1'b0;
  postfix_t    postfix_q [$];

  logic [7:0]  expr_buf [$];
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  logic        stall_long     = 1'b0;
  int unsigned long_cnt       = 0;
  int unsigned cyc            = 0;
  int unsigned n_fail         = 0;
  int unsigned n_chars        = 0;
  int unsigned n_exprs        = 0;
  int unsigned n_results      = 0;
  int unsigned n_ovf_end      = 0;
  int unsigned n_unb_end      = 0;
  int unsigned phase_chars    = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic op_code_t op_of(input logic [7:0] c);
    case (c)
      CH_OPEN: return OP_OPEN;
      CH_POW:  return OP_POW;
      CH_MUL:  return OP_MUL;
      CH_DIV:  return OP_DIV;
      CH_MOD:  return OP_MOD;
      CH_ADD:  return OP_ADD;
      CH_SUB:  return OP_SUB;
      default: return OP_NONE;
    endcase
  endfunction

  function automatic void emit(input logic [7:0] c, input logic h);
    postfix_q.push_back('{c, h, 1'b0, ST_OK});
  endfunction

  function automatic void push_op(input op_code_t op);
    if (op_depth >= STACK_DEPTH) begin
      ovf_seen = 1'b1;
    end else begin
      op_stk[op_depth] = op;
      op_depth++;
    end
  endfunction

  function automatic void shunt_char(input logic [7:0] c, input logic last);
    op_code_t    op;
    op_code_t    top;
    logic        hit;
    int unsigned base;
    postfix_t    tail;
    base = postfix_q.size();
    op = op_of(c);
    if (c == CH_CLOSE) begin
      hit = 1'b0;
      while (op_depth > 0 && !hit) begin
        op_depth--;
        top = op_stk[op_depth];
        if (top == OP_OPEN) hit = 1'b1;
        else emit(op_sym[top], 1'b1);
      end
      if (!hit) unb_seen = 1'b1;
    end else if (op == OP_OPEN) begin
      push_op(op);
    end else if (op != OP_NONE) begin
      while (op_depth > 0 && op_rank[op_stk[op_depth - 1]] >= op_rank[op]) begin
        op_depth--;
        emit(op_sym[op_stk[op_depth]], 1'b1);
      end
      push_op(op);
    end else begin
      emit(c, 1'b1);
    end
    if (last) begin
      while (op_depth > 0) begin
        op_depth--;
        if (op_stk[op_depth] == OP_OPEN) unb_seen = 1'b1;
        else emit(op_sym[op_stk[op_depth]], 1'b1);
      end
      if (postfix_q.size() == base) emit(8'h00, 1'b0);
      tail = postfix_q.pop_back();
      tail.eoe = 1'b1;
      tail.st  = unb_seen ? ST_UNB : (ovf_seen ? ST_OVF : ST_OK);
      postfix_q.push_back(tail);
      n_exprs++;
      if (unb_seen) n_unb_end++;
      else if (ovf_seen) n_ovf_end++;
      ovf_seen = 1'b0;
      unb_seen = 1'b0;
    end
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    if ($urandom_range(3) != 0) begin
      c = 8'h61 + 8'($urandom_range(25));
    end else begin
      c = 8'($urandom_range(255));
      while (op_of(c) != OP_NONE || c == CH_CLOSE) c = 8'($urandom_range(255));
    end
    return c;
  endfunction

  function automatic void gen_expr(input int unsigned lvl);
    int unsigned n_terms;
    int unsigned i;
    n_terms = 1 + $urandom_range(3);
    for (i = 0; i < n_terms; i++) begin
      if (i != 0) expr_buf.push_back(op_sym[1 + $urandom_range(5)]);
      if (lvl < 4 && $urandom_range(99) < 25) begin
        expr_buf.push_back(CH_OPEN);
        gen_expr(lvl + 1);
        expr_buf.push_back(CH_CLOSE);
      end else begin
        expr_buf.push_back(rand_operand());
      end
    end
  endfunction

  // nesting around the stack depth; the closes sometimes match the opens, sometimes fall short or run over
  function automatic void gen_deep();
    int unsigned k;
    int unsigned m;
    k = $urandom_range(36, 28);
    if ($urandom_range(1)) m = (k > STACK_DEPTH) ? STACK_DEPTH : k;
    else m = $urandom_range(k + 1, k - 2);
    repeat (k) expr_buf.push_back(CH_OPEN);
    expr_buf.push_back(rand_operand());
    repeat (m) begin
      if ($urandom_range(99) < 30) begin
        expr_buf.push_back(op_sym[1 + $urandom_range(5)]);
        expr_buf.push_back(rand_operand());
      end
      expr_buf.push_back(CH_CLOSE);
    end
    if ($urandom_range(1)) begin
      expr_buf.push_back(op_sym[1 + $urandom_range(5)]);
      expr_buf.push_back(rand_operand());
    end
  endfunction

  function automatic void gen_noise();
    repeat (1 + $urandom_range(7)) begin
      if ($urandom_range(1)) expr_buf.push_back($urandom_range(1) ? CH_CLOSE
                                                                 : op_sym[$urandom_range(6)]);
      else expr_buf.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic put_char(input logic [7:0] c, input logic last, input logic typed,
                          input postfix_t res);
    int unsigned base;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    base = postfix_q.size();
    shunt_char(c, last);
    if (typed) begin
      while (postfix_q.size() > base) void'(postfix_q.pop_back());
      postfix_q.push_back(res);
    end
    n_chars++;
    phase_chars++;
    @(negedge clk);
  endtask

  task automatic send_expr();
    int unsigned i;
    for (i = 0; i < expr_buf.size(); i++)
      put_char(expr_buf[i], (i + 1 == expr_buf.size()), 1'b0, '0);
    expr_buf.delete();
  endtask

  task automatic send_random(input int unsigned quota);
    int unsigned r;
    phase_chars = 0;
    while (phase_chars < quota) begin
      r = $urandom_range(99);
      if (r < 6) gen_deep();
      else if (r < 80) gen_expr(0);
      else gen_noise();
      send_expr();
    end
  endtask

  always @(negedge clk) begin
    if (stall_long && long_cnt < LONG_HOLD) begin
      out_tready <= 1'b0;
      long_cnt++;
    end else begin
      out_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    postfix_t want;
    postfix_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tuser[0], out_tlast, out_tdata[9:8]};
      n_results++;
      if (postfix_q.size() == 0) begin
        n_fail++;
        if (n_fail <= 10)
          $display("unexpected result %0d: char %h has %b end %b status %0d",
                   n_results, got.ch, got.has, got.eoe, got.st);
      end else begin
        want = postfix_q.pop_front();
        if (got !== want) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch at result %0d: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                     n_results, want.ch, want.has, want.eoe, want.st,
                     got.ch, got.has, got.eoe, got.st);
        end
      end
    end
  end

  initial begin
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cyc, postfix_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned i;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    for (i = 0; i < N_DIR; i++)
      put_char(dir_tbl[i].ch, dir_tbl[i].last, dir_tbl[i].typed, dir_tbl[i].res);
    for (i = 0; i < 4; i++) begin
      src_idle_pct   = src_pct[i];
      sink_stall_pct = sink_pct[i];
      if (i == 0) begin
        gen_deep();
        send_expr();
      end
      send_random(PHASE_CHARS);
    end
    // output held off while input keeps coming
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    stall_long     = 1'b1;
    send_random(PRESS_CHARS);
    in_tvalid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d characters in %0d expressions through five traffic mixes, %0d results",
             n_chars, n_exprs, n_results);
    $display("%0d expressions ended in overflow, %0d unbalanced, %0d failures",
             n_ovf_end, n_unb_end, n_fail);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
